### design/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BBA_MAX_BLOCKS = 65536;
  localparam int LEN_W          = 14;
  localparam int BLK_W          = 16;
  localparam int CMD_W          = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 14'd8192;
  localparam logic [7:0]       FIRST_BIT = 8'h80;

  localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_USED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_USED,
    OP_FREE,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [BLK_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_number;
    logic             found;
  } out_item_t;

  // byte unit result
  typedef struct packed {
    logic       nonzero;
    logic [2:0] first_bit;
    logic [7:0] new_byte;
  } byte_res_t;

endpackage : bba_pkg
`default_nettype wire

### design/bba_map_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_map_ram
// Free map store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bba_map_ram #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : bba_map_ram
`default_nettype wire

### design/bba_byte_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_byte_unit
// Shared byte unit: finds the first free bit (MSB first) and builds the
// updated map byte for allocate, mark used and mark free.
// ----------------------------------------------------------------------------
module bba_byte_unit
  import bba_pkg::*;
(
  input  wire logic [7:0] map_byte,
  input  wire op_t        op,
  input  wire logic [2:0] bit_sel,
  output byte_res_t       res
);

  logic [2:0] first;
  logic [7:0] mask;

  always_comb begin
    first = 3'd0;
    // later iterations are higher bits, so the MSB wins
    for (int j = 0; j < 8; j++) begin
      if (map_byte[j]) begin
        first = 3'(7 - j);
      end
    end
  end

  always_comb begin
    res.nonzero   = |map_byte;
    res.first_bit = first;
    mask          = FIRST_BIT >> ((op == OP_ALLOC) ? first : bit_sel);
    case (op)
      OP_ALLOC: res.new_byte = map_byte & ~mask;
      OP_USED:  res.new_byte = map_byte & ~mask;
      OP_FREE:  res.new_byte = map_byte | mask;
      default:  res.new_byte = map_byte;
    endcase
  end

endmodule : bba_byte_unit
`default_nettype wire

### design/bitmap_block_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Next-fit free map for disk blocks with allocate / mark used / mark free.
// ----------------------------------------------------------------------------
// One bit per block, set = free, MSB of each byte is the lowest block. After
// reset a clearing pass writes every map byte to zero (all blocks used); no
// command transaction is taken until it ends, while configuration writes are
// taken at any time. Every command holds the block busy until its result is
// registered. A mark goes through accept, map read, update and write back,
// and result; a mark beyond the map goes straight to the result. An allocate
// reads and checks map bytes from the search cursor on the single map read
// port, one read step and one check step per byte, so it takes longer the
// farther the next free byte lies past the cursor. An allocate that finds no
// byte to examine (cursor at or past the length) goes straight from accept
// to result. A result that the sink stalls holds in the output register;
// the next command can be accepted meanwhile but finishes only after that
// result has left.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = BBA_MAX_BLOCKS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // command transactions
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  // result transactions
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  // configuration: bitmap_length_bytes
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data
);

  localparam int MAP_BYTES = MAX_BLOCKS / 8;
  localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  localparam logic [LEN_W-1:0]  MAP_BYTES_L = LEN_W'(MAP_BYTES);
  localparam logic [BLK_W:0]    MAP_BITS_L  = (BLK_W + 1)'(MAP_BYTES * 8);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(MAP_BYTES - 1);

  // registers
  state_t            state, state_next;
  op_t               op, op_next;
  logic [LEN_W-1:0]  idx, idx_next;         // byte being examined / marked
  logic [2:0]        bit_sel, bit_sel_next;
  logic [ADDR_W-1:0] cursor, cursor_next;
  logic [ADDR_W-1:0] clr_cnt, clr_cnt_next;
  logic [LEN_W-1:0]  length;
  logic [BLK_W-1:0]  res_block, res_block_next;
  logic              res_found, res_found_next;

  // map port controls
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        rd_data;
  byte_res_t         ures;

  logic              in_accept;
  logic              resp_load;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  idx_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // search stops at the configured length, capped at the map size
  assign limit   = (length > MAP_BYTES_L) ? MAP_BYTES_L : length;
  assign idx_inc = idx + LEN_W'(1);

  bba_map_ram #(
    .DEPTH  (MAP_BYTES),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  bba_byte_unit u_unit (
    .map_byte (rd_data),
    .op       (op),
    .bit_sel  (bit_sel),
    .res      (ures)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      cursor  <= '0;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      cursor  <= cursor_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length <= cfg_data;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    op        <= op_next;
    idx       <= idx_next;
    bit_sel   <= bit_sel_next;
    res_block <= res_block_next;
    res_found <= res_found_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_data.block_number <= res_block;
      out_data.found        <= res_found;
    end
  end

  // sequencer
  always_comb begin
    state_next     = state;
    op_next        = op;
    idx_next       = idx;
    bit_sel_next   = bit_sel;
    cursor_next    = cursor;
    clr_cnt_next   = clr_cnt;
    res_block_next = res_block;
    res_found_next = res_found;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = idx[ADDR_W-1:0];
    wr_data        = ures.new_byte;
    resp_load      = 1'b0;

    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = 8'h00;
        if (clr_cnt == LAST_ADDR) begin
          state_next = ST_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          res_block_next = '0;
          res_found_next = 1'b0;
          bit_sel_next   = in_data.block_index[2:0];
          case (in_data.command)
            CMD_ALLOC: begin
              op_next  = OP_ALLOC;
              idx_next = LEN_W'(cursor);
              // cursor at or past length: nothing to examine
              state_next = (LEN_W'(cursor) < limit) ? ST_READ : ST_RESP;
            end
            CMD_MARK_USED, CMD_MARK_FREE: begin
              op_next  = (in_data.command == CMD_MARK_FREE) ? OP_FREE : OP_USED;
              idx_next = LEN_W'(in_data.block_index >> 3);
              // block beyond the map: no change, not found
              state_next = ({1'b0, in_data.block_index} < MAP_BITS_L) ?
                           ST_READ : ST_RESP;
            end
            default: begin
              op_next    = OP_NONE;
              state_next = ST_RESP;
            end
          endcase
        end
      end

      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_CHECK;
      end

      ST_CHECK: begin
        if (op == OP_ALLOC) begin
          if (ures.nonzero) begin
            wr_en          = 1'b1;
            res_block_next = {idx[BLK_W-4:0], ures.first_bit};
            res_found_next = 1'b1;
            cursor_next    = idx[ADDR_W-1:0];
            state_next     = ST_RESP;
          end else if (idx_inc < limit) begin
            idx_next   = idx_inc;
            state_next = ST_READ;
          end else begin
            state_next = ST_RESP;
          end
        end else begin
          wr_en          = 1'b1;
          res_found_next = 1'b1;
          state_next     = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid || !out_stall) begin
          resp_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> wr_en && wr_data == 8'h00)
    else $error("clearing pass must write zero each cycle");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.block_number == '0)
    else $error("not-found result must carry block zero");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK && op == OP_ALLOC && ures.nonzero |=>
      LEN_W'(cursor) < limit)
    else $error("cursor moved past search limit");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ && op == OP_ALLOC |-> idx < limit)
    else $error("allocate read beyond search limit");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != ST_IDLE && state != ST_CLEAR)
    else $error("accepted command did not start");

endmodule : bitmap_block_allocator
`default_nettype wire
